@@ rtl/lfdw_pkg.sv @@
package lfdw_pkg;

    // Panel geometry
    localparam int FRAME_BYTES = 1024;
    localparam int COLUMNS     = 128;
    localparam int IDX_W       = 10;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int COL_W       = $clog2(COLUMNS);
    localparam int BEATS_MAX   = 4;
    localparam int CNT_W       = $clog2(BEATS_MAX + 1);
    localparam int PTR_W       = $clog2(BEATS_MAX);

    // Controller command bytes
    localparam logic [7:0] CMD_PAGE   = 8'hB0;
    localparam logic [7:0] CMD_COL_HI = 8'h10;
    localparam logic [7:0] CMD_COL_LO = 8'h00;

    // Item operation
    typedef enum logic
    {
        OP_DIFF = 1'b0,
        OP_FULL = 1'b1
    } op_t;

    // One output beat
    typedef struct packed
    {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last;
    } beat_t;

    // Beats produced by one item, handed to the sequencer
    typedef struct packed
    {
        logic [CNT_W-1:0]            cnt;
        beat_t [BEATS_MAX-1:0]       beats;
    } burst_t;

endpackage

@@ rtl/lcd_frame_diff_writer_core.sv @@
// Throughput: an item that emits nothing is taken every cycle; an item that emits a
// burst of two or four beats leaves stage one only once the previous burst is drained
// by the output link, which moves one byte per cycle while m_tready is high.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes all 1024 entries
// of the shadow memory and s_tready stays low until it ends.
module lcd_frame_diff_writer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // byte_index[9:0], pixel_byte[17:10], zero pad
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tuser,   // is_data
    output logic        m_tlast
);
    import lfdw_pkg::*;

    logic              in_take;
    logic [IDX_W-1:0]  in_idx;
    logic [7:0]        in_pix;

    logic              s1_valid_reg;
    logic              s1_op_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic [7:0]        s1_pix_reg;
    logic              s1_byp_reg;
    logic [7:0]        s1_byp_data_reg;

    logic              clr_busy;
    logic [7:0]        rd_data;
    logic [7:0]        shadow_q;
    logic              idx_ok;
    logic [IDX_W-1:0]  page_full;
    logic [7:0]        col8;
    logic [7:0]        page_cmd;
    logic [7:0]        col_hi;
    logic [7:0]        col_lo;
    logic              col_zero;
    burst_t            burst;
    logic              seq_free;
    logic              s1_adv;
    logic              wr_en;

    assign in_idx  = s_tdata[IDX_W-1:0];
    assign in_pix  = s_tdata[IDX_W+7:IDX_W];
    assign s_tready = !clr_busy && (!s1_valid_reg || s1_adv);
    assign in_take = s_tvalid && s_tready;

    // Stage one register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Payload, plus forwarding of a shadow write that lands on the same edge as the read
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg       <= s_tuser;
            s1_idx_reg      <= in_idx;
            s1_pix_reg      <= in_pix;
            s1_byp_reg      <= wr_en && (s1_idx_reg == in_idx);
            s1_byp_data_reg <= s1_pix_reg;
        end
    end

    lfdw_shadow u_shadow
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_take),
        .rd_addr (in_idx[ADDR_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_idx_reg[ADDR_W-1:0]),
        .wr_data (s1_pix_reg),
        .busy    (clr_busy)
    );

    // Command bytes and burst build
    assign shadow_q  = s1_byp_reg ? s1_byp_data_reg : rd_data;
    assign idx_ok    = ({1'b0, s1_idx_reg} < (IDX_W + 1)'(FRAME_BYTES));
    assign page_full = s1_idx_reg >> COL_W;
    assign col8      = 8'(s1_idx_reg[COL_W-1:0]);
    assign page_cmd  = CMD_PAGE | {4'h0, page_full[3:0]};
    assign col_hi    = CMD_COL_HI | {4'h0, col8[7:4]};
    assign col_lo    = CMD_COL_LO | {4'h0, col8[3:0]};
    assign col_zero  = (col8 == 8'h00);

    always_comb
    begin
        burst.cnt      = '0;
        burst.beats[0] = '{out_byte: page_cmd,   is_data: 1'b0, last: 1'b0};
        burst.beats[1] = '{out_byte: col_hi,     is_data: 1'b0, last: 1'b0};
        burst.beats[2] = '{out_byte: col_lo,     is_data: 1'b0, last: 1'b0};
        burst.beats[3] = '{out_byte: s1_pix_reg, is_data: 1'b1, last: 1'b1};
        if (idx_ok)
        begin
            case (op_t'(s1_op_reg))
                OP_DIFF:
                begin
                    if (shadow_q != s1_pix_reg)
                    begin
                        burst.cnt = CNT_W'(4);
                    end
                end
                OP_FULL:
                begin
                    if (col_zero)
                    begin
                        burst.cnt = CNT_W'(4);
                    end
                    else
                    begin
                        burst.cnt      = CNT_W'(2);
                        burst.beats[1] = burst.beats[3];
                    end
                end
                default:
                begin
                    burst.cnt = '0;
                end
            endcase
        end
    end

    // Item leaves stage one; a changed byte in diff mode updates the shadow
    assign s1_adv = s1_valid_reg && ((burst.cnt == '0) || seq_free);
    assign wr_en  = s1_adv && (op_t'(s1_op_reg) == OP_DIFF) && (burst.cnt != '0);

    lfdw_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (s1_adv && (burst.cnt != '0)),
        .burst    (burst),
        .free     (seq_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !s_tready)
        else $error("input taken during clearing pass");
    a_wr_diff_only: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> s1_valid_reg && (shadow_q != s1_pix_reg))
        else $error("shadow written for unchanged byte");
    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_idx_reg))
        else $error("stage one lost a stalled item");
`endif

endmodule

@@ rtl/lfdw_shadow.sv @@
module lfdw_shadow
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [lfdw_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                 rd_data,
    input  logic                       wr_en,
    input  logic [lfdw_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                 wr_data,
    output logic                       busy
);
    import lfdw_pkg::*;

    logic [7:0]        mem [FRAME_BYTES];
    logic [7:0]        rd_data_reg;
    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [7:0]        wd;

    // Clearing pass after reset, one entry a cycle
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(FRAME_BYTES - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Write port shared between clearing pass and item updates
    always_comb
    begin
        we = wr_en;
        wa = wr_addr;
        wd = wr_data;
        if (clr_busy_reg)
        begin
            we = 1'b1;
            wa = clr_addr_reg;
            wd = 8'h00;
        end
    end

    // Memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

`ifndef NO_ASSERTIONS
    a_no_wr_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !wr_en && !rd_en)
        else $error("shadow accessed during clearing pass");
    a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_busy_reg) |-> $past(clr_addr_reg) == ADDR_W'(FRAME_BYTES - 1))
        else $error("clearing pass ended early");
    a_clear_stays: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_busy_reg |=> !clr_busy_reg)
        else $error("clearing pass restarted");
`endif

endmodule

@@ rtl/lfdw_seq.sv @@
module lfdw_seq
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  lfdw_pkg::burst_t burst,
    output logic            free,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,   // out_byte[7:0]
    output logic            m_tuser,   // is_data
    output logic            m_tlast
);
    import lfdw_pkg::*;

    beat_t [BEATS_MAX-1:0] beats_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [PTR_W-1:0]      ptr_reg;
    logic [PTR_W-1:0]      ptr_next;
    logic                  take;
    beat_t                 cur;

    assign take = m_tvalid && m_tready;
    assign free = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_tready);

    // Beat counter and read pointer
    always_comb
    begin
        cnt_next = cnt_reg;
        ptr_next = ptr_reg;
        if (take)
        begin
            cnt_next = cnt_reg - 1'b1;
            ptr_next = ptr_reg + 1'b1;
        end
        if (load)
        begin
            cnt_next = burst.cnt;
            ptr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ptr_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
        end
    end

    // Beat payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beats_reg <= burst.beats;
        end
    end

    assign cur      = beats_reg[ptr_reg];
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = cur.out_byte;
    assign m_tuser  = cur.is_data;
    assign m_tlast  = cur.last;

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("burst loaded over pending beats");
    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (cnt_reg == CNT_W'(1))))
        else $error("last flag out of step with beat count");
    a_load_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (burst.cnt == CNT_W'(2) || burst.cnt == CNT_W'(4)))
        else $error("bad burst length");
`endif

endmodule
